// ===== hw/rtl/ffra_pkg.sv =====
// Shared types, codes and defaults of the first-fit range allocator.
package ffra_pkg;

  localparam int unsigned MAX_RANGES_DEF = 64;
  localparam logic [31:0] HEAP_SIZE_RST  = 32'd65536;

  // Command codes carried on s_tuser
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NO_FIT = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_ZERO   = 2'd3;

  // Register word index (paddr[2])
  localparam logic REG_HEAP_SIZE = 1'b0;

  // One free range as held in the range memory
  typedef struct packed {
    logic [31:0] len;
    logic [31:0] start;
  } range_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN,
    S_A_UPD,
    S_F_END,
    S_F_SCAN,
    S_F_PRED,
    S_F_MERGE1,
    S_F_MERGE2,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_INIT,
    S_FINISH
  } state_t;

endpackage

// ===== hw/rtl/first_fit_range_allocator_unit.sv =====
// Top level of the first-fit range allocator: sequencer, shared adder and range memory.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser = command, s_tdata = req_size, free_offset
//  m_*       out  m_tvalid/m_tready  m_tdata = ok, grant_offset, status, ranges_in_use
//  APB       in   psel/penable       paddr[2] selects heap_size, pready tied high
//
// Sequence: an allocate scans the ranges up to the first that fits and then carves
// the request off its front; an exact fit instead shifts the later entries down, and a
// miss ends at the end of the list. A free scans to the insert position and merges with
// its neighbours, then shifts entries up to open a slot or down to close one after a
// double merge. The sequencer returns to idle before the next command is taken. The
// range memory has a single write port and is read and written once per cycle.
// Reset: the range list is empty (count zero) until the first init command;
// heap_size returns to 65536. The memory itself is not cleared.
// Stalls: a finished result waits in the output register while the next command is
// taken; the sequencer holds in its finish state only if that register is still full.
module first_fit_range_allocator_unit #(
  parameter int unsigned MAX_RANGES = ffra_pkg::MAX_RANGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] req_size, [63:32] free_offset
  input  logic [1:0]  s_tuser,   // [1:0] command
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [0] ok, [32:1] grant_offset, [34:33] status,
                                 // [41:35] ranges_in_use, [47:42] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);
  localparam logic [CW-1:0] ONE     = CW'(1);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [31:0] heap_size;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ffra_pkg::REG_HEAP_SIZE) ? heap_size : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size <= ffra_pkg::HEAP_SIZE_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ffra_pkg::REG_HEAP_SIZE) begin
      heap_size <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  ffra_pkg::state_t state, state_next;

  logic [CW-1:0]    count;       // ranges held
  logic [CW-1:0]    idx;         // scan position
  logic [CW-1:0]    ptr;         // shift position
  logic [31:0]      size_r;
  logic [31:0]      off_r;
  ffra_pkg::range_t prev;        // entry just below the scan position
  ffra_pkg::range_t cur;         // entry at the scan stop
  logic [31:0]      acc;
  logic [32:0]      new_end;
  logic             pred;
  logic             succ;
  logic             res_ok;
  logic [1:0]       res_status;
  logic [31:0]      res_grant;

  logic             out_ok;
  logic [31:0]      out_grant;
  logic [1:0]       out_status;
  logic [6:0]       out_count;

  // Range memory: one write and one registered read per cycle
  ffra_pkg::range_t mem [MAX_RANGES];
  ffra_pkg::range_t rdata;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  ffra_pkg::range_t mem_wdata;
  logic [IW-1:0]    rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Shared adder / subtractor
  // ---------------------------------------------------------------------------
  logic [31:0] alu_a, alu_b;
  logic        alu_sub;
  logic [32:0] alu_res;
  logic [31:0] alu_sat;

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_sat = alu_res[32] ? 32'hFFFF_FFFF : alu_res[31:0];

  // Decodes
  logic accept, finish_load, scan_end, fits, exact, more_dn, more_up;

  assign s_tready    = (state == ffra_pkg::S_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign finish_load = (state == ffra_pkg::S_FINISH) && (!m_tvalid || m_tready);
  assign scan_end    = (idx == count);
  assign fits        = !alu_res[32];                        // len >= size, or start <= off
  assign exact       = !alu_res[32] && (alu_res[31:0] == 32'd0);
  assign more_dn     = (ptr + ONE) < count;
  assign more_up     = ptr > idx;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ffra_pkg::S_IDLE: begin
        if (accept) begin
          case (s_tuser)
            ffra_pkg::CMD_ALLOC: begin
              state_next = (s_tdata[31:0] == 32'd0) ? ffra_pkg::S_FINISH : ffra_pkg::S_A_SCAN;
            end
            ffra_pkg::CMD_FREE: begin
              state_next = (s_tdata[31:0] == 32'd0) ? ffra_pkg::S_FINISH : ffra_pkg::S_F_END;
            end
            ffra_pkg::CMD_INIT: state_next = ffra_pkg::S_INIT;
            default:            state_next = ffra_pkg::S_FINISH;
          endcase
        end
      end
      ffra_pkg::S_A_SCAN: begin
        if (scan_end) begin
          state_next = ffra_pkg::S_FINISH;
        end else if (fits) begin
          state_next = exact ? ffra_pkg::S_SHIFT_DN : ffra_pkg::S_A_UPD;
        end
      end
      ffra_pkg::S_A_UPD:  state_next = ffra_pkg::S_FINISH;
      ffra_pkg::S_F_END:  state_next = ffra_pkg::S_F_SCAN;
      ffra_pkg::S_F_SCAN: begin
        if (scan_end || !fits) begin
          state_next = ffra_pkg::S_F_PRED;
        end
      end
      ffra_pkg::S_F_PRED: state_next = ffra_pkg::S_F_MERGE1;
      ffra_pkg::S_F_MERGE1: begin
        if (pred && succ) begin
          state_next = ffra_pkg::S_F_MERGE2;
        end else if (pred || succ || count == MAX_CNT) begin
          state_next = ffra_pkg::S_FINISH;
        end else begin
          state_next = ffra_pkg::S_SHIFT_UP;
        end
      end
      ffra_pkg::S_F_MERGE2: state_next = ffra_pkg::S_SHIFT_DN;
      ffra_pkg::S_SHIFT_DN: begin
        if (!more_dn) begin
          state_next = ffra_pkg::S_FINISH;
        end
      end
      ffra_pkg::S_SHIFT_UP: begin
        if (!more_up) begin
          state_next = ffra_pkg::S_FINISH;
        end
      end
      ffra_pkg::S_INIT:   state_next = ffra_pkg::S_FINISH;
      ffra_pkg::S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = ffra_pkg::S_IDLE;
        end
      end
      default: state_next = ffra_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memory port and adder controls
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_waddr = idx[IW-1:0];
    mem_wdata = '{len: size_r, start: off_r};
    alu_a     = rdata.len;
    alu_b     = size_r;
    alu_sub   = 1'b0;
    case (state)
      ffra_pkg::S_A_SCAN: begin
        // compare len against the request; prefetch the next entry
        rd_addr = IW'(idx + ONE);
        alu_a   = rdata.len;
        alu_b   = size_r;
        alu_sub = 1'b1;
      end
      ffra_pkg::S_A_UPD: begin
        // carve the request off the front of the range
        alu_a     = cur.start;
        alu_b     = size_r;
        mem_we    = 1'b1;
        mem_wdata = '{len: acc, start: alu_res[31:0]};
      end
      ffra_pkg::S_F_END: begin
        alu_a = off_r;
        alu_b = size_r;
      end
      ffra_pkg::S_F_SCAN: begin
        rd_addr = IW'(idx + ONE);
        alu_a   = off_r;
        alu_b   = rdata.start;
        alu_sub = 1'b1;
      end
      ffra_pkg::S_F_PRED: begin
        alu_a = prev.start;
        alu_b = prev.len;
      end
      ffra_pkg::S_F_MERGE1: begin
        alu_a   = pred ? prev.len : cur.len;
        alu_b   = size_r;
        rd_addr = IW'(count - ONE);
        if (pred && !succ) begin
          mem_we    = 1'b1;
          mem_waddr = IW'(idx - ONE);
          mem_wdata = '{len: alu_sat, start: prev.start};
        end else if (succ && !pred) begin
          mem_we    = 1'b1;
          mem_wdata = '{len: alu_sat, start: off_r};
        end
      end
      ffra_pkg::S_F_MERGE2: begin
        // fold successor into predecessor, then drop the successor entry
        alu_a     = acc;
        alu_b     = cur.len;
        rd_addr   = IW'(idx + ONE);
        mem_we    = 1'b1;
        mem_waddr = IW'(idx - ONE);
        mem_wdata = '{len: alu_sat, start: prev.start};
      end
      ffra_pkg::S_SHIFT_DN: begin
        rd_addr   = IW'(ptr + ONE + ONE);
        mem_we    = more_dn;
        mem_waddr = ptr[IW-1:0];
        mem_wdata = rdata;
      end
      ffra_pkg::S_SHIFT_UP: begin
        rd_addr   = IW'(ptr - ONE - ONE);
        mem_we    = 1'b1;
        mem_waddr = more_up ? ptr[IW-1:0] : idx[IW-1:0];
        mem_wdata = more_up ? rdata : ffra_pkg::range_t'{len: size_r, start: off_r};
      end
      ffra_pkg::S_INIT: begin
        mem_we    = (heap_size != 32'd0);
        mem_waddr = '0;
        mem_wdata = '{len: heap_size, start: 32'd0};
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffra_pkg::S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ffra_pkg::S_SHIFT_DN: begin
          if (!more_dn) begin
            count <= count - ONE;
          end
        end
        ffra_pkg::S_SHIFT_UP: begin
          if (!more_up) begin
            count <= count + ONE;
          end
        end
        ffra_pkg::S_INIT: begin
          count <= (heap_size != 32'd0) ? ONE : '0;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ffra_pkg::S_IDLE: begin
        if (accept) begin
          size_r     <= s_tdata[31:0];
          off_r      <= s_tdata[63:32];
          idx        <= '0;
          res_ok     <= 1'b0;
          res_grant  <= 32'd0;
          res_status <= ((s_tuser == ffra_pkg::CMD_ALLOC || s_tuser == ffra_pkg::CMD_FREE) &&
                         s_tdata[31:0] == 32'd0) ? ffra_pkg::STAT_ZERO : ffra_pkg::STAT_OK;
        end
      end
      ffra_pkg::S_A_SCAN: begin
        if (scan_end) begin
          res_status <= ffra_pkg::STAT_NO_FIT;
        end else if (fits) begin
          res_ok    <= 1'b1;
          res_grant <= rdata.start;
          acc       <= alu_res[31:0];
          cur       <= rdata;
          ptr       <= idx;
        end else begin
          idx <= idx + ONE;
        end
      end
      ffra_pkg::S_F_END: begin
        new_end <= alu_res;
      end
      ffra_pkg::S_F_SCAN: begin
        if (scan_end || !fits) begin
          cur <= rdata;
        end else begin
          prev <= rdata;
          idx  <= idx + ONE;
        end
      end
      ffra_pkg::S_F_PRED: begin
        pred <= (idx != '0) && (alu_res == {1'b0, off_r});
        succ <= !scan_end && (new_end == {1'b0, cur.start});
      end
      ffra_pkg::S_F_MERGE1: begin
        acc <= alu_sat;
        ptr <= count;
        if (!pred && !succ && count == MAX_CNT) begin
          res_status <= ffra_pkg::STAT_FULL;
        end else begin
          res_ok <= 1'b1;
        end
      end
      ffra_pkg::S_F_MERGE2: begin
        ptr <= idx;
      end
      ffra_pkg::S_SHIFT_DN: begin
        ptr <= ptr + ONE;
      end
      ffra_pkg::S_SHIFT_UP: begin
        ptr <= ptr - ONE;
      end
      ffra_pkg::S_INIT: begin
        if (heap_size == 32'd0) begin
          res_status <= ffra_pkg::STAT_ZERO;
        end else begin
          res_ok <= 1'b1;
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // Output register: load when the previous beat is gone or leaving
  always_ff @(posedge clk) begin
    if (finish_load) begin
      out_ok     <= res_ok;
      out_grant  <= res_grant;
      out_status <= res_status;
      out_count  <= 7'(count);
    end
  end

  assign m_tdata = {6'd0, out_count, out_status, out_grant, out_ok};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("range count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second command taken while busy");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ffra_pkg::S_FINISH))
    else $error("result beat raised outside finish");

  a_insert_has_room: assert property (@(posedge clk) disable iff (rst)
    (state == ffra_pkg::S_SHIFT_UP) |-> (count < MAX_CNT))
    else $error("insert into a full list");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_ok) |-> (out_status == ffra_pkg::STAT_OK))
    else $error("ok beat with error status");

  a_grant_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_grant != 32'd0) |-> out_ok)
    else $error("nonzero grant on failed command");

endmodule
